/* rtl/pbcal_pkg.sv */
package pbcal_pkg;

    localparam int LEN_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int VARINT_MAX    = 10;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_LEN     = 3'd1,
        PH_DATA    = 3'd2,
        PH_SKIPVAR = 3'd3,
        PH_STOP    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        FC_WIDTH   = 3'd0,
        FC_HEIGHT  = 3'd1,
        FC_MODEL   = 3'd2,
        FC_DISTORT = 3'd3,
        FC_INTRIN  = 3'd4,
        FC_EXTRIN  = 3'd5,
        FC_SKIP    = 3'd7
    } t_field;

    typedef enum logic [1:0] {
        KIND_SCALAR = 2'd0,
        KIND_START  = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_LONG  = 2'd2,
        ST_WIRE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        WT_VARINT = 3'd0,
        WT_FIX64  = 3'd1,
        WT_LEN    = 3'd2,
        WT_SGROUP = 3'd3,
        WT_EGROUP = 3'd4,
        WT_FIX32  = 3'd5,
        WT_BAD6   = 3'd6,
        WT_BAD7   = 3'd7
    } t_wire;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } t_in;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [2:0]  field_code;
        logic [63:0] value;
        logic [1:0]  status;
        logic        run_last;
    } t_out;

endpackage

/* rtl/pbcal_decoder.sv */
module pbcal_decoder #(
    parameter int LEN_WIDTH = pbcal_pkg::LEN_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  pbcal_pkg::t_in   i_byte,
    output logic [1:0]       o_num,
    output pbcal_pkg::t_out  o_res_a,
    output pbcal_pkg::t_out  o_res_b
);

    pbcal_pkg::t_phase     r_phase, n_phase;
    logic [63:0]           r_acc, n_acc;
    logic [3:0]            r_cnt, n_cnt;
    pbcal_pkg::t_field     r_field, n_field;
    logic [LEN_WIDTH-1:0]  r_left, n_left;
    logic [2:0]            r_eb, n_eb;
    logic [63:0]           r_ea, n_ea;
    pbcal_pkg::t_status    r_stop, n_stop;

    logic [6:0]            sh;
    logic [63:0]           vs_acc;
    logic [3:0]            vs_inc;
    logic                  vs_cont;
    logic                  vs_long;
    logic [7:0]            b;
    logic [LEN_WIDTH-1:0]  left_dec;
    logic [63:0]           ea_or;
    pbcal_pkg::t_status    err;
    pbcal_pkg::t_status    end_st;
    logic                  step_vld;
    pbcal_pkg::t_out       step_res;
    pbcal_pkg::t_out       end_res;
    pbcal_pkg::t_wire      wt;
    logic [60:0]           fn;

    assign b        = i_byte.data_byte;
    assign sh       = {r_cnt, 3'b000} - {3'b000, r_cnt};
    assign vs_acc   = r_acc | ({56'd0, 1'b0, b[6:0]} << sh[5:0]);
    assign vs_inc   = r_cnt + 4'd1;
    assign vs_cont  = b[7];
    assign vs_long  = vs_cont && (vs_inc >= 4'(pbcal_pkg::VARINT_MAX));
    assign left_dec = r_left - LEN_WIDTH'(1);
    assign wt       = pbcal_pkg::t_wire'(vs_acc[2:0]);
    assign fn       = vs_acc[63:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pbcal_pkg::PH_TAG;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_field <= pbcal_pkg::FC_WIDTH;
            r_left  <= '0;
            r_eb    <= '0;
            r_ea    <= '0;
            r_stop  <= pbcal_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_field <= n_field;
            r_left  <= n_left;
            r_eb    <= n_eb;
            r_ea    <= n_ea;
            r_stop  <= n_stop;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_field  = r_field;
        n_left   = r_left;
        n_eb     = r_eb;
        n_ea     = r_ea;
        n_stop   = r_stop;
        err      = pbcal_pkg::ST_OK;
        step_vld = 1'b0;
        step_res = '0;
        ea_or    = '0;
        end_st   = pbcal_pkg::ST_OK;

        case (r_phase)
            pbcal_pkg::PH_TAG: begin
                if (vs_long) begin
                    err = pbcal_pkg::ST_LONG;
                end else if (!vs_cont) begin
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_field = pbcal_pkg::FC_SKIP;
                    case (wt)
                        pbcal_pkg::WT_VARINT: begin
                            n_phase = pbcal_pkg::PH_SKIPVAR;
                        end
                        pbcal_pkg::WT_FIX64: begin
                            n_left  = LEN_WIDTH'(8);
                            n_eb    = '0;
                            n_ea    = '0;
                            n_phase = pbcal_pkg::PH_DATA;
                        end
                        pbcal_pkg::WT_LEN: begin
                            if (fn == 61'd4) n_field = pbcal_pkg::FC_MODEL;
                            else if (fn == 61'd5) n_field = pbcal_pkg::FC_DISTORT;
                            else if (fn == 61'd6) n_field = pbcal_pkg::FC_INTRIN;
                            else if (fn == 61'd10) n_field = pbcal_pkg::FC_EXTRIN;
                            n_phase = pbcal_pkg::PH_LEN;
                        end
                        pbcal_pkg::WT_FIX32: begin
                            if (fn == 61'd2) n_field = pbcal_pkg::FC_WIDTH;
                            else if (fn == 61'd3) n_field = pbcal_pkg::FC_HEIGHT;
                            n_left  = LEN_WIDTH'(4);
                            n_eb    = '0;
                            n_ea    = '0;
                            n_phase = pbcal_pkg::PH_DATA;
                        end
                        pbcal_pkg::WT_BAD6, pbcal_pkg::WT_BAD7: begin
                            err = pbcal_pkg::ST_WIRE;
                        end
                        default: begin
                            n_phase = pbcal_pkg::PH_TAG;
                        end
                    endcase
                end else begin
                    n_acc = vs_acc;
                    n_cnt = vs_inc;
                end
            end
            pbcal_pkg::PH_LEN: begin
                if (vs_long) begin
                    err = pbcal_pkg::ST_LONG;
                end else if (!vs_cont) begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (|(vs_acc >> LEN_WIDTH)) begin
                        err = pbcal_pkg::ST_TRUNC;
                    end else begin
                        if (r_field != pbcal_pkg::FC_SKIP) begin
                            step_vld            = 1'b1;
                            step_res.item_kind  = pbcal_pkg::KIND_START;
                            step_res.field_code = r_field;
                        end
                        if (vs_acc == 64'd0) begin
                            n_phase = pbcal_pkg::PH_TAG;
                        end else begin
                            n_left  = vs_acc[LEN_WIDTH-1:0];
                            n_eb    = '0;
                            n_ea    = '0;
                            n_phase = pbcal_pkg::PH_DATA;
                        end
                    end
                end else begin
                    n_acc = vs_acc;
                    n_cnt = vs_inc;
                end
            end
            pbcal_pkg::PH_DATA: begin
                n_left = left_dec;
                if (r_field == pbcal_pkg::FC_WIDTH || r_field == pbcal_pkg::FC_HEIGHT) begin
                    ea_or = r_ea | ({56'd0, b} << {r_eb[1:0], 3'b000});
                    n_ea  = ea_or;
                    n_eb  = r_eb + 3'd1;
                    if (left_dec == '0) begin
                        step_vld            = 1'b1;
                        step_res.item_kind  = pbcal_pkg::KIND_SCALAR;
                        step_res.field_code = r_field;
                        step_res.value      = {32'd0, ea_or[31:0]};
                    end
                end else if (r_field == pbcal_pkg::FC_MODEL) begin
                    step_vld            = 1'b1;
                    step_res.item_kind  = pbcal_pkg::KIND_DATA;
                    step_res.field_code = pbcal_pkg::FC_MODEL;
                    step_res.value      = {56'd0, b};
                end else if (r_field != pbcal_pkg::FC_SKIP) begin
                    ea_or = r_ea | ({56'd0, b} << {r_eb, 3'b000});
                    if (r_eb == 3'd7) begin
                        step_vld            = 1'b1;
                        step_res.item_kind  = pbcal_pkg::KIND_DATA;
                        step_res.field_code = r_field;
                        step_res.value      = ea_or;
                        n_ea                = '0;
                        n_eb                = '0;
                    end else begin
                        n_ea = ea_or;
                        n_eb = r_eb + 3'd1;
                    end
                end
                if (left_dec == '0) begin
                    n_phase = pbcal_pkg::PH_TAG;
                end
            end
            pbcal_pkg::PH_SKIPVAR: begin
                if (vs_long) begin
                    err = pbcal_pkg::ST_LONG;
                end else if (!vs_cont) begin
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = pbcal_pkg::PH_TAG;
                end else begin
                    n_acc = vs_acc;
                    n_cnt = vs_inc;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (err != pbcal_pkg::ST_OK) begin
            n_stop  = err;
            n_phase = pbcal_pkg::PH_STOP;
        end

        if (n_phase == pbcal_pkg::PH_STOP) begin
            end_st = n_stop;
        end else if (n_phase == pbcal_pkg::PH_TAG && n_cnt == 4'd0) begin
            end_st = pbcal_pkg::ST_OK;
        end else begin
            end_st = pbcal_pkg::ST_TRUNC;
        end

        if (i_byte.end_of_payload) begin
            n_phase = pbcal_pkg::PH_TAG;
            n_acc   = '0;
            n_cnt   = '0;
            n_field = pbcal_pkg::FC_WIDTH;
            n_left  = '0;
            n_eb    = '0;
            n_ea    = '0;
            n_stop  = pbcal_pkg::ST_OK;
        end

        step_res.run_last = !i_byte.end_of_payload;
    end

    always_comb begin
        end_res           = '0;
        end_res.item_kind = pbcal_pkg::KIND_END;
        end_res.status    = end_st;
        end_res.run_last  = 1'b1;
        o_num             = {1'b0, step_vld} + {1'b0, i_byte.end_of_payload};
        o_res_a           = step_vld ? step_res : end_res;
        o_res_b           = end_res;
    end

endmodule

/* rtl/pbcal_queue.sv */
module pbcal_queue #(
    parameter int DEPTH = pbcal_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_wr_num,
    input  pbcal_pkg::t_out  i_wr_a,
    input  pbcal_pkg::t_out  i_wr_b,
    output logic             o_room,
    output logic             o_valid,
    output pbcal_pkg::t_out  o_data,
    input  logic             i_stall
);

    localparam int AW = $clog2(DEPTH);

    pbcal_pkg::t_out  r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_cnt, n_cnt;
    logic [AW-1:0]    wr_ptr_b;
    logic             pop;

    assign wr_ptr_b = r_wr_ptr + AW'(1);
    assign pop      = (r_cnt != '0) && !i_stall;
    assign o_valid  = (r_cnt != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_room   = (r_cnt <= (AW + 1)'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_wr_num);
        n_rd_ptr = pop ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_cnt    = r_cnt + (AW + 1)'(i_wr_num) - (AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_a;
        end
        if (i_wr_num == 2'd2) begin
            r_mem[wr_ptr_b] <= i_wr_b;
        end
    end

endmodule

/* rtl/protobuf_calib_field_parser.sv */
// streaming decoder for a protobuf calibration payload, one byte per request
// input channel: i_in_valid / o_in_stall with i_in_data (byte, end flag);
// a request is taken at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall with o_out_data; each byte gives
// zero, one or two results (field start, scalar, string byte or packed
// element, and an end report on the final byte), run_last marks the last one
// a taken byte waits in the input register, and its results are offered from the queue once written
// throughput: one byte per cycle; the decode step is a single registered
// pass, results go into a four-entry queue and the input stalls while the
// queue cannot take two more results, so a receiver taking one result per
// cycle sees no stall for streams with at most one result per byte
// when the receiver stalls, the queue fills and o_in_stall rises once it holds
// more than two results; the head result holds steady until it is taken
// reset (i_rst_n low at a clock edge) empties the queue and input register
// and returns the decoder to waiting for a tag
module protobuf_calib_field_parser #(
    parameter int LEN_WIDTH = pbcal_pkg::LEN_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pbcal_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pbcal_pkg::t_out  o_out_data
);

    logic             r_in_vld;
    pbcal_pkg::t_in   r_in;
    logic             room;
    logic             fire;
    logic [1:0]       dec_num;
    logic [1:0]       wr_num;
    pbcal_pkg::t_out  res_a;
    pbcal_pkg::t_out  res_b;

    assign fire       = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign wr_num     = fire ? dec_num : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    pbcal_decoder #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in),
        .o_num   (dec_num),
        .o_res_a (res_a),
        .o_res_b (res_b)
    );

    pbcal_queue #(
        .DEPTH(pbcal_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_num (wr_num),
        .i_wr_a   (res_a),
        .i_wr_b   (res_b),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data),
        .i_stall  (i_out_stall)
    );

endmodule
